### rtl/core/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the contraction credit scorer.
// ----------------------------------------------------------------------------
package ccs_pkg;

	localparam int DIST_W  = 32;
	localparam int NODE_W  = 32;
	localparam int CFG_W   = 24;
	localparam int SCORE_W = 17;
	localparam int IDX_W   = 2;

	localparam logic [CFG_W-1:0]   EPSILON_RST = 24'd66;
	localparam logic [SCORE_W-1:0] SCORE_MAX   = 17'h1FFFF;
	localparam logic [DIST_W-1:0]  RATIO_MAX   = 32'hFFFFFFFF;

	typedef enum logic [IDX_W-1:0] {
		CFG_ALPHA   = 2'd0,
		CFG_EPSILON = 2'd1,
		CFG_MODE    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] alpha;
		logic [CFG_W-1:0] epsilon;
		logic             distance_mode;
	} ccs_cfg_t;

	typedef struct packed {
		logic              has_alt;
		logic [NODE_W-1:0] node;
		logic [DIST_W-1:0] best_dist;
		logic [DIST_W-1:0] src;
		logic [DIST_W-1:0] wit;
	} ccs_entry_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_NB,
		F_NB_W,
		F_SRC,
		F_SRC_W,
		F_WIT,
		F_WIT_W,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_CHK,
		B_WR_GO,
		B_WR_W,
		B_CR_GO,
		B_CR_W,
		B_MUL0,
		B_MUL1,
		B_PROG,
		B_IRR_GO,
		B_IRR_W,
		B_CRED,
		B_OUT
	} back_state_t;

endpackage

### rtl/core/ccs_if.sv
// ----------------------------------------------------------------------------
// ccs_if
// Item and score channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface ccs_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_distance_in;
	logic [31:0] witness_distance_in;
	logic [31:0] witness_node;
	logic [31:0] neighbor_node;
	logic [31:0] neighbor_distance_in;
	logic        neighbor_present;
	logic        last_neighbor;

	modport source (
		output valid, source_distance_in, witness_distance_in, witness_node,
		       neighbor_node, neighbor_distance_in, neighbor_present, last_neighbor,
		input  ready
	);
	modport sink (
		input  valid, source_distance_in, witness_distance_in, witness_node,
		       neighbor_node, neighbor_distance_in, neighbor_present, last_neighbor,
		output ready
	);
endinterface

interface ccs_out_if;
	logic        valid;
	logic        ready;
	logic        has_alternative;
	logic [31:0] alternative_node;
	logic [31:0] wit_ratio;
	logic [16:0] cf_ratio;
	logic [16:0] cert_prog;
	logic [16:0] irreplaceability;
	logic [16:0] credit;
	logic        baseline_too_small;

	modport source (
		output valid, has_alternative, alternative_node, wit_ratio,
		       cf_ratio, cert_prog, irreplaceability,
		       credit, baseline_too_small,
		input  ready
	);
	modport sink (
		input  valid, has_alternative, alternative_node, wit_ratio,
		       cf_ratio, cert_prog, irreplaceability,
		       credit, baseline_too_small,
		output ready
	);
endinterface

### rtl/core/ccs_isqrt.sv
// ----------------------------------------------------------------------------
// ccs_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ccs_isqrt #(
	parameter  int XW = 48,
	localparam int RW = (XW + 1) / 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] x,
	output logic          done,
	output logic [RW-1:0] root
);
	localparam int RADW = 2 * RW;
	localparam int CW   = $clog2(RW + 1);

	logic [RADW-1:0] rad_q;
	logic [RW-1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;

	logic [RW+1:0] t_rem;
	logic [RW+1:0] trial;
	logic          ge;

	assign t_rem = {rem_q, rad_q[RADW-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign ge    = t_rem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(RW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RADW'(x);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= RW'(ge ? t_rem - trial : t_rem);
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/core/ccs_div.sv
// ----------------------------------------------------------------------------
// ccs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccs_div #(
	parameter int NW = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NW-1:0]             num,
	input  logic [ccs_pkg::DIST_W-1:0] den,
	output logic                      done,
	output logic [NW-1:0]             quot
);
	import ccs_pkg::*;

	localparam int CNW = $clog2(NW + 1);

	logic [NW-1:0]     n_q;
	logic [DIST_W-1:0] rem_q;
	logic [DIST_W-1:0] den_q;
	logic [CNW-1:0]    cnt_q;
	logic              run_q;
	logic              done_q;

	logic [DIST_W:0] t;
	logic [DIST_W:0] diff;
	logic            ge;

	assign t    = {rem_q, n_q[NW-1]};
	assign diff = t - {1'b0, den_q};
	assign ge   = t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			n_q   <= {n_q[NW-2:0], ge};
			rem_q <= ge ? diff[DIST_W-1:0] : t[DIST_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

### rtl/core/ccs_front.sv
// ----------------------------------------------------------------------------
// ccs_front
// Takes items, converts distances and tracks the nearest non-witness neighbor.
// ----------------------------------------------------------------------------
module ccs_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccs_pkg::ccs_cfg_t   cfg,
	ccs_in_if.sink              items,
	output logic                entry_valid,
	input  logic                entry_ready,
	output ccs_pkg::ccs_entry_t entry
);
	import ccs_pkg::*;

	localparam int XW = DIST_W + FRAC_BITS;
	localparam int RW = (XW + 1) / 2;

	front_state_t state_q, state_d;

	logic [DIST_W-1:0] src_raw_q, wit_raw_q, nd_raw_q, src_q, wit_q, best_dist_q;
	logic [NODE_W-1:0] wnode_q, nnode_q, best_node_q;
	logic              present_q, last_q, best_found_q;

	logic              sq_start, sq_done;
	logic [RW-1:0]     sq_root;
	logic [DIST_W-1:0] sel_raw, cv;
	logic              upd_en, src_ld, wit_ld, better, waiting;
	front_state_t      after_nb;

	always_comb begin
		unique case (state_q)
			F_SRC, F_SRC_W: sel_raw = src_raw_q;
			F_WIT, F_WIT_W: sel_raw = wit_raw_q;
			default:        sel_raw = nd_raw_q;
		endcase
	end

	ccs_isqrt #(.XW(XW)) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.x     (XW'(sel_raw) << FRAC_BITS),
		.done  (sq_done),
		.root  (sq_root)
	);

	assign waiting  = state_q == F_NB_W || state_q == F_SRC_W || state_q == F_WIT_W;
	assign cv       = waiting ? DIST_W'(sq_root) : sel_raw;
	assign after_nb = last_q ? F_SRC : F_IDLE;
	assign better   = (nnode_q != wnode_q) &&
		(!best_found_q || cv < best_dist_q ||
		 (cv == best_dist_q && nnode_q < best_node_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (items.valid) state_d = F_NB;
			F_NB: begin
				if (!present_q) state_d = after_nb;
				else if (cfg.distance_mode) state_d = F_NB_W;
				else state_d = after_nb;
			end
			F_NB_W:  if (sq_done) state_d = after_nb;
			F_SRC:   state_d = cfg.distance_mode ? F_SRC_W : F_WIT;
			F_SRC_W: if (sq_done) state_d = F_WIT;
			F_WIT:   state_d = cfg.distance_mode ? F_WIT_W : F_PUSH;
			F_WIT_W: if (sq_done) state_d = F_PUSH;
			F_PUSH:  if (entry_ready) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		items.ready = state_q == F_IDLE;
		entry_valid = state_q == F_PUSH;
		sq_start    = cfg.distance_mode &&
			((state_q == F_NB && present_q) || state_q == F_SRC || state_q == F_WIT);
		upd_en      = present_q &&
			((state_q == F_NB && !cfg.distance_mode) || (state_q == F_NB_W && sq_done));
		src_ld      = (state_q == F_SRC && !cfg.distance_mode) ||
			(state_q == F_SRC_W && sq_done);
		wit_ld      = (state_q == F_WIT && !cfg.distance_mode) ||
			(state_q == F_WIT_W && sq_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			best_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_en && better) best_found_q <= 1'b1;
			else if (entry_valid && entry_ready) best_found_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			src_raw_q <= items.source_distance_in;
			wit_raw_q <= items.witness_distance_in;
			wnode_q   <= items.witness_node;
			nnode_q   <= items.neighbor_node;
			nd_raw_q  <= items.neighbor_distance_in;
			present_q <= items.neighbor_present;
			last_q    <= items.last_neighbor;
		end
		if (upd_en && better) begin
			best_dist_q <= cv;
			best_node_q <= nnode_q;
		end
		if (src_ld) src_q <= cv;
		if (wit_ld) wit_q <= cv;
	end

	assign entry.has_alt   = best_found_q;
	assign entry.node      = best_found_q ? best_node_q : '0;
	assign entry.best_dist = best_dist_q;
	assign entry.src       = src_q;
	assign entry.wit       = wit_q;

endmodule

### rtl/core/ccs_queue.sv
// ----------------------------------------------------------------------------
// ccs_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ccs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  ccs_pkg::ccs_entry_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output ccs_pkg::ccs_entry_t pop_data
);
	import ccs_pkg::*;

	ccs_entry_t mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

endmodule

### rtl/core/ccs_back.sv
// ----------------------------------------------------------------------------
// ccs_back
// Computes ratios, progress, irreplaceability and credit for one event.
// ----------------------------------------------------------------------------
module ccs_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccs_pkg::ccs_cfg_t   cfg,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  ccs_pkg::ccs_entry_t entry,
	ccs_out_if.source           scores
);
	import ccs_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int QW = DIST_W + F;
	localparam int PW = F + 1;
	localparam int AW = CFG_W + 2 * F;
	localparam int SW = (PW > SCORE_W) ? PW : SCORE_W;

	localparam logic [QW-1:0] ONE_Q  = QW'(1) << F;
	localparam logic [QW-1:0] FULL_Q = QW'(1) << (2 * F);
	localparam logic [AW-1:0] FULL_A = AW'(1) << (2 * F);
	localparam logic [PW-1:0] ONE_P  = {1'b1, {F{1'b0}}};

	back_state_t state_q, state_d;

	ccs_entry_t        ent_q;
	logic [QW-1:0]     wr_q;
	logic [PW-1:0]     cr_q, prog_q, irr_q, cred_q;
	logic [AW-1:0]     acc_q;
	logic              bts_q;

	logic              div_start, div_done;
	logic [QW-1:0]     div_num, div_quot, cr_max;
	logic [DIST_W-1:0] div_den;
	logic              small_src, irr_go;
	logic [PW-1:0]     prog_d;
	logic [2*PW-1:0]   cprod;

	function automatic logic [SCORE_W-1:0] sat17(input logic [PW-1:0] v);
		logic [SW-1:0] e;
		e = SW'(v);
		return (e > SW'(SCORE_MAX)) ? SCORE_MAX : e[SCORE_W-1:0];
	endfunction

	always_comb begin
		unique case (state_q)
			B_CR_GO:  div_num = QW'(ent_q.best_dist) << F;
			B_IRR_GO: div_num = QW'(cr_q - wr_q[PW-1:0]) << F;
			default:  div_num = QW'(ent_q.wit) << F;
		endcase
		div_den = (state_q == B_IRR_GO) ? DIST_W'(cr_q) : ent_q.src;
	end

	ccs_div #(.NW(QW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign small_src = ent_q.src <= DIST_W'(cfg.epsilon);
	assign cr_max    = (div_quot < wr_q) ? wr_q : div_quot;
	assign irr_go    = (DIST_W'(cr_q) > DIST_W'(cfg.epsilon)) && (wr_q < QW'(cr_q));
	assign cprod     = {{PW{1'b0}}, prog_q} * {{PW{1'b0}}, irr_q};

	always_comb begin
		if (cfg.alpha == '0) prog_d = ONE_P;
		else if (wr_q >= FULL_Q || acc_q >= FULL_A) prog_d = '0;
		else prog_d = PW'((FULL_A - acc_q) >> F);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:   if (pop_valid) state_d = B_CHK;
			B_CHK:    state_d = small_src ? B_OUT : B_WR_GO;
			B_WR_GO:  state_d = B_WR_W;
			B_WR_W:   if (div_done) state_d = ent_q.has_alt ? B_CR_GO : B_MUL0;
			B_CR_GO:  state_d = B_CR_W;
			B_CR_W:   if (div_done) state_d = B_MUL0;
			B_MUL0:   state_d = B_MUL1;
			B_MUL1:   state_d = B_PROG;
			B_PROG:   state_d = irr_go ? B_IRR_GO : B_CRED;
			B_IRR_GO: state_d = B_IRR_W;
			B_IRR_W:  if (div_done) state_d = B_CRED;
			B_CRED:   state_d = B_OUT;
			B_OUT:    if (scores.ready) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop_ready    = state_q == B_IDLE;
		div_start    = state_q == B_WR_GO || state_q == B_CR_GO || state_q == B_IRR_GO;
		scores.valid = state_q == B_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: if (pop_valid) ent_q <= entry;
			B_CHK: begin
				bts_q  <= small_src;
				wr_q   <= '0;
				cr_q   <= '0;
				prog_q <= '0;
				irr_q  <= '0;
				cred_q <= '0;
			end
			B_WR_W: if (div_done) begin
				wr_q <= div_quot;
				cr_q <= ONE_P;
			end
			B_CR_W: if (div_done) cr_q <= (cr_max > ONE_Q) ? ONE_P : cr_max[PW-1:0];
			B_MUL0: acc_q <= AW'(cfg.alpha) * AW'(wr_q[F-1:0]);
			B_MUL1: acc_q <= acc_q + ((AW'(cfg.alpha) * AW'(wr_q[2*F-1:F])) << F);
			B_PROG: begin
				prog_q <= prog_d;
				irr_q  <= '0;
			end
			B_IRR_W: if (div_done) irr_q <= div_quot[PW-1:0];
			B_CRED:  cred_q <= PW'(cprod >> F);
			default: ;
		endcase
	end

	assign scores.has_alternative    = ent_q.has_alt;
	assign scores.alternative_node   = ent_q.node;
	assign scores.wit_ratio          = (wr_q > QW'(RATIO_MAX)) ? RATIO_MAX : wr_q[DIST_W-1:0];
	assign scores.cf_ratio           = sat17(cr_q);
	assign scores.cert_prog          = sat17(prog_q);
	assign scores.irreplaceability   = sat17(irr_q);
	assign scores.credit             = sat17(cred_q);
	assign scores.baseline_too_small = bts_q;

endmodule

### rtl/core/contraction_credit_scorer.sv
// ----------------------------------------------------------------------------
// contraction_credit_scorer
// Scores one pruning event from a stream of neighbor items.
// ----------------------------------------------------------------------------
// Front: in squared mode an item with a present neighbor takes one serial square
// root, in true mode none; a last item adds two more roots.
// Back: up to three serial divisions per event; a two-entry queue decouples
// it from the front.
// Reset clears control state and loads alpha = one, epsilon = 66, squared mode.
module contraction_credit_scorer #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ccs_pkg::IDX_W-1:0]      cfg_idx,
	input  logic [ccs_pkg::CFG_W-1:0]      cfg_data,
	ccs_in_if.sink                         items,
	ccs_out_if.source                      scores
);
	import ccs_pkg::*;

	localparam logic [CFG_W-1:0] ALPHA_RST = CFG_W'(1) << FRAC_BITS;

	ccs_cfg_t   cfg_q;
	ccs_entry_t f_entry, b_entry;
	logic       f_valid, f_ready, b_valid, b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha         <= ALPHA_RST;
			cfg_q.epsilon       <= EPSILON_RST;
			cfg_q.distance_mode <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ALPHA:   cfg_q.alpha         <= cfg_data;
				CFG_EPSILON: cfg_q.epsilon       <= cfg_data;
				CFG_MODE:    cfg_q.distance_mode <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	ccs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.items      (items),
		.entry_valid(f_valid),
		.entry_ready(f_ready),
		.entry      (f_entry)
	);

	ccs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_entry),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_entry)
	);

	ccs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.entry    (b_entry),
		.scores   (scores)
	);

	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		scores.valid && scores.baseline_too_small |->
			scores.wit_ratio == '0 && scores.cf_ratio == '0 &&
			scores.cert_prog == '0 && scores.credit == '0)
		else $error("baseline result carries nonzero ratios");

	a_no_alt_node: assert property (@(posedge clk) disable iff (!arst_n)
		scores.valid && !scores.has_alternative |-> scores.alternative_node == '0)
		else $error("alternative node without alternative");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scores.valid |-> scores.credit <= scores.cert_prog &&
			scores.credit <= scores.irreplaceability)
		else $error("credit exceeds its factors");

endmodule

### verif/contraction_credit_scorer_chk.sv
// ----------------------------------------------------------------------------
// contraction_credit_scorer_chk
// Scoreboard for the contraction credit scorer. It watches register writes,
// item and score transfers, predicts each score from its own copy of the
// registers and the running best neighbor, and compares the scores in order.
// ----------------------------------------------------------------------------
module contraction_credit_scorer_chk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ccs_pkg::IDX_W-1:0] cfg_idx,
	input  logic [ccs_pkg::CFG_W-1:0] cfg_data,
	ccs_in_if                         items,
	ccs_out_if                        scores,
	output int                        pending,
	output int                        fails
);
	timeunit 1ns;
	timeprecision 1ps;
	import ccs_pkg::*;

	localparam int FRAC = 16;
	localparam longint unsigned ONE = 64'd1 << FRAC;

	typedef struct packed {
		logic               has_alternative;
		logic [NODE_W-1:0]  alternative_node;
		logic [DIST_W-1:0]  wit_ratio;
		logic [SCORE_W-1:0] cf_ratio;
		logic [SCORE_W-1:0] cert_prog;
		logic [SCORE_W-1:0] irreplaceability;
		logic [SCORE_W-1:0] credit;
		logic               baseline_too_small;
	} score_t;

	logic [CFG_W-1:0]  alpha_q;
	logic [CFG_W-1:0]  eps_q;
	logic              sq_mode_q;
	logic              near_found;
	logic [DIST_W-1:0] near_dist;
	logic [NODE_W-1:0] near_node;
	score_t            score_q[$];

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned to_linear(input logic [DIST_W-1:0] raw);
		if (sq_mode_q)
			return int_sqrt(longint'(raw) << FRAC);
		return longint'(raw);
	endfunction

	function automatic score_t score_event(input longint unsigned src,
			input longint unsigned wit);
		score_t s;
		longint unsigned wr, cr, prog, irr, full, thr;
		s = '0;
		s.has_alternative  = near_found;
		s.alternative_node = near_found ? near_node : '0;
		if (src <= longint'(eps_q)) begin
			s.baseline_too_small = 1'b1;
			return s;
		end
		wr = (wit << FRAC) / src;
		cr = ONE;
		if (near_found) begin
			cr = (longint'(near_dist) << FRAC) / src;
			if (cr < wr)
				cr = wr;
			if (cr > ONE)
				cr = ONE;
		end
		full = 64'd1 << (2 * FRAC);
		if (alpha_q == 0) begin
			prog = ONE;
		end else begin
			thr = (full + alpha_q - 1) / alpha_q;
			prog = (wr >= thr) ? 0 : (full - longint'(alpha_q) * wr) >> FRAC;
		end
		irr = 0;
		if (cr > longint'(eps_q) && wr < cr)
			irr = ((cr - wr) << FRAC) / cr;
		if (irr > ONE)
			irr = ONE;
		if (prog > ONE)
			prog = ONE;
		s.wit_ratio        = (wr > 64'hFFFFFFFF) ? RATIO_MAX : wr[31:0];
		s.cf_ratio         = cr[SCORE_W-1:0];
		s.cert_prog        = prog[SCORE_W-1:0];
		s.irreplaceability = irr[SCORE_W-1:0];
		s.credit           = SCORE_W'((prog * irr) >> FRAC);
		return s;
	endfunction

	task automatic check_field(input string name, input longint unsigned exp_v,
			input longint unsigned act_v, inout bit bad);
		if (exp_v != act_v) begin
			bad = 1'b1;
			if (fails < 10)
				$display("%0t mismatch %s: expected %0h actual %0h",
					$realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint unsigned d;
		score_t e;
		bit bad;
		if (!arst_n) begin
			alpha_q    <= CFG_W'(ONE);
			eps_q      <= EPSILON_RST;
			sq_mode_q  <= 1'b1;
			near_found = 1'b0;
			near_dist  = '0;
			near_node  = '0;
			score_q.delete();
			pending    <= 0;
			fails      <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_ALPHA:   alpha_q   <= cfg_data;
					CFG_EPSILON: eps_q     <= cfg_data;
					CFG_MODE:    sq_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (items.valid && items.ready) begin
				if (items.neighbor_present && items.neighbor_node != items.witness_node) begin
					d = to_linear(items.neighbor_distance_in);
					if (!near_found || d < near_dist ||
							(d == near_dist && items.neighbor_node < near_node)) begin
						near_found = 1'b1;
						near_dist  = d[31:0];
						near_node  = items.neighbor_node;
					end
				end
				if (items.last_neighbor) begin
					score_q.insert(score_q.size(),
						score_event(to_linear(items.source_distance_in),
						to_linear(items.witness_distance_in)));
					near_found = 1'b0;
					near_dist  = '0;
					near_node  = '0;
				end
			end
			if (scores.valid && scores.ready) begin
				if (score_q.size() == 0) begin
					if (fails < 10)
						$display("%0t score transfer with nothing expected", $realtime);
					fails <= fails + 1;
				end else begin
					e = score_q.pop_front();
					bad = 1'b0;
					check_field("has_alternative", e.has_alternative,
						scores.has_alternative, bad);
					check_field("alternative_node", e.alternative_node,
						scores.alternative_node, bad);
					check_field("wit_ratio", e.wit_ratio, scores.wit_ratio, bad);
					check_field("cf_ratio", e.cf_ratio, scores.cf_ratio, bad);
					check_field("cert_prog", e.cert_prog, scores.cert_prog, bad);
					check_field("irreplaceability", e.irreplaceability,
						scores.irreplaceability, bad);
					check_field("credit", e.credit, scores.credit, bad);
					check_field("baseline_too_small", e.baseline_too_small,
						scores.baseline_too_small, bad);
					if (bad)
						fails <= fails + 1;
				end
			end
			pending <= score_q.size();
		end
	end

endmodule

### verif/contraction_credit_scorer_tb.sv
// ----------------------------------------------------------------------------
// contraction_credit_scorer_tb
// Drives pruning events through the scorer under several register settings,
// with random gaps on both channels, a long score back-pressure stretch and
// drain pauses; the checker predicts and compares every score.
// ----------------------------------------------------------------------------
module contraction_credit_scorer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ccs_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_idx;
	logic [CFG_W-1:0]  cfg_data;
	int                pending;
	int                fails;
	bit                gaps_on;
	bit                hold_req;
	int                sent;

	ccs_in_if  item_ch ();
	ccs_out_if score_ch ();

	contraction_credit_scorer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.items    (item_ch),
		.scores   (score_ch)
	);

	contraction_credit_scorer_chk i_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.items    (item_ch),
		.scores   (score_ch),
		.pending  (pending),
		.fails    (fails)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// score side: random stalls, one long hold-off on request
	initial begin
		score_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				score_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 1'b0;
			end
			score_ch.ready <= !(gaps_on && $urandom_range(99) < 33);
		end
	end

	task automatic send_item(input logic [31:0] src, wit, wn, nn, nd,
			input logic np, last);
		while (gaps_on && $urandom_range(99) < 33) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid                <= 1'b1;
		item_ch.source_distance_in   <= src;
		item_ch.witness_distance_in  <= wit;
		item_ch.witness_node         <= wn;
		item_ch.neighbor_node        <= nn;
		item_ch.neighbor_distance_in <= nd;
		item_ch.neighbor_present     <= np;
		item_ch.last_neighbor        <= last;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] a, e, input logic m);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_ALPHA;
		cfg_data <= a;
		@(posedge clk);
		cfg_idx  <= CFG_EPSILON;
		cfg_data <= e;
		@(posedge clk);
		cfg_idx  <= CFG_MODE;
		cfg_data <= CFG_W'(m);
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	function automatic logic [31:0] pick_dist(input logic [31:0] base);
		case ($urandom_range(9))
			0:       return $urandom_range(300);
			1, 2:    return $urandom;
			3:       return base;
			default: return 32'((longint'(base) * $urandom_range(2048)) >> 10);
		endcase
	endfunction

	function automatic logic [31:0] pick_id();
		return ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
	endfunction

	task automatic random_event();
		int n;
		logic [31:0] src, wit, wn;
		n   = $urandom_range(1, 6);
		src = ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h7FFFFFFF);
		wn  = pick_id();
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(7) == 0) begin
				src = pick_dist(src);
				wn  = pick_id();
			end
			wit = pick_dist(src);
			send_item(src, wit, wn, ($urandom_range(4) == 0) ? wn : pick_id(),
				pick_dist(src), $urandom_range(9) != 0, k == n - 1);
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		cfg_we   <= 1'b0;
		cfg_idx  <= CFG_ALPHA;
		cfg_data <= '0;
		gaps_on  = 1'b1;
		hold_req = 1'b0;
		sent     = 0;
		item_ch.valid                <= 1'b0;
		item_ch.source_distance_in   <= '0;
		item_ch.witness_distance_in  <= '0;
		item_ch.witness_node         <= '0;
		item_ch.neighbor_node        <= '0;
		item_ch.neighbor_distance_in <= '0;
		item_ch.neighbor_present     <= 1'b0;
		item_ch.last_neighbor        <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed events at reset settings
		send_item(0, 0, 0, 0, 0, 1'b0, 1'b1);
		send_item(32'hFFFFFFFF, 0, 9, 9, 5, 1'b1, 1'b1);
		send_item(32'h10000, 32'h10000, 1, 5, 32'h4000, 1'b1, 1'b0);
		send_item(32'h10000, 32'h10000, 1, 3, 32'h4000, 1'b1, 1'b0);
		send_item(32'h10000, 32'h30000, 1, 4, 32'h4000, 1'b0, 1'b1);
		send_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE,
			32'hFFFFFFFF, 1'b1, 1'b0);
		send_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			0, 1'b1, 1'b1);
		send_item(67, 66, 2, 3, 32'h1000, 1'b1, 1'b1);
		send_item(1, 1, 0, 1, 0, 1'b1, 1'b1);
		send_item(32'h40000, 32'h20000, 0, 32'hFFFFFFFF, 32'h40000, 1'b1, 1'b1);
		while (sent < 300)
			random_event();
		drain();

		load_regs(24'hFFFFFF, 24'd1, 1'b0);
		hold_req = 1'b1;
		send_item(2, 0, 0, 1, 1, 1'b1, 1'b1);
		send_item(1, 32'hFFFFFFFF, 5, 6, 32'hFFFFFFFF, 1'b1, 1'b1);
		send_item(32'h10000, 32'h1, 5, 6, 32'h10000, 1'b1, 1'b1);
		while (sent < 600)
			random_event();
		drain();

		load_regs(24'h010000, 24'hFFFFFF, 1'b1);
		gaps_on = 1'b0;
		while (sent < 900)
			random_event();
		gaps_on = 1'b1;
		drain();

		load_regs(24'h018000, 24'd66, 1'b0);
		while (sent < 1200)
			random_event();
		drain();

		for (int p = 0; p < 2; p++) begin
			load_regs($urandom_range(24'h010000, 24'hFFFFFF) >> $urandom_range(7),
				$urandom_range(1, 24'hFFFF) >> $urandom_range(15), p[0]);
			while (sent < 1200 + 275 * (p + 1))
				random_event();
			drain();
		end

		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
